### src/hpc_pkg.sv
package hpc_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_SET_POWER = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  // Operating modes.
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_AUTO     = 2'd1;
  localparam logic [1:0] MODE_HAND     = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE           = 3'd0;
  localparam logic [2:0] REG_TARGET_RETURN  = 3'd1;
  localparam logic [2:0] REG_MAX_FLOW       = 3'd2;
  localparam logic [2:0] REG_HYSTERESIS     = 3'd3;
  localparam logic [2:0] REG_AUTO_CEILING   = 3'd4;
  localparam logic [2:0] REG_MANUAL_CEILING = 3'd5;
  localparam logic [2:0] REG_PERIOD         = 3'd6;
  localparam logic [2:0] REG_DEBOUNCE       = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Power and temperature constants.
  localparam logic [7:0] PDM_FULL_SCALE   = 8'd100;
  localparam logic [6:0] POWER_MAX        = 7'd100;
  localparam logic [6:0] FROST_TARGET_MAX = 7'd15;
  localparam int         TEMP_W           = 12;
  localparam int         CALC_W           = 16;
  // Reciprocal of ten with 15 fractional bits; exact for magnitudes up to 2048.
  localparam logic [11:0] RECIP_TEN   = 12'd3277;
  localparam int          RECIP_SHIFT = 15;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  target_return_temp;
    logic [6:0]  max_flow_temp;
    logic [4:0]  hysteresis_deg;
    logic [6:0]  auto_ceiling;
    logic [6:0]  manual_ceiling;
    logic [15:0] period_ms;
    logic [15:0] debounce_ms;
  } hpc_cfg_t;

endpackage

### src/hpc_cfg_regs.sv
module hpc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [hpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            cfg_ready,
  output hpc_pkg::hpc_cfg_t               cfg
);
  import hpc_pkg::*;

  hpc_cfg_t cfg_r;
  hpc_cfg_t cfg_nxt;

  // The user must let writes land only while the block is idle; it is not enforced here, and the port is always open.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:           cfg_nxt.mode               = cfg_data[1:0];
        REG_TARGET_RETURN:  cfg_nxt.target_return_temp = cfg_data[6:0];
        REG_MAX_FLOW:       cfg_nxt.max_flow_temp      = cfg_data[6:0];
        REG_HYSTERESIS:     cfg_nxt.hysteresis_deg     = cfg_data[4:0];
        REG_AUTO_CEILING:   cfg_nxt.auto_ceiling       = cfg_data[6:0];
        REG_MANUAL_CEILING: cfg_nxt.manual_ceiling     = cfg_data[6:0];
        REG_PERIOD:         cfg_nxt.period_ms          = cfg_data[15:0];
        REG_DEBOUNCE:       cfg_nxt.debounce_ms        = cfg_data[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode               <= MODE_AUTO;
      cfg_r.target_return_temp <= 7'd40;
      cfg_r.max_flow_temp      <= 7'd75;
      cfg_r.hysteresis_deg     <= 5'd3;
      cfg_r.auto_ceiling       <= 7'd100;
      cfg_r.manual_ceiling     <= 7'd100;
      cfg_r.period_ms          <= 16'd1000;
      cfg_r.debounce_ms        <= 16'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/hpc_auto_power.sv
module hpc_auto_power (
  input  hpc_pkg::hpc_cfg_t                cfg,
  input  logic                             relay_state,
  input  logic signed [hpc_pkg::TEMP_W-1:0] return_temp_dc,
  input  logic signed [hpc_pkg::TEMP_W-1:0] flow_temp_dc,
  output logic [6:0]                       auto_power
);
  import hpc_pkg::*;

  logic signed [CALC_W-1:0] r_s;
  logic signed [CALC_W-1:0] f_s;
  logic signed [CALC_W-1:0] tgt_s;
  logic signed [CALC_W-1:0] pmax_s;
  logic signed [CALC_W-1:0] tgt_x10;
  logic signed [CALC_W-1:0] flow_limit;
  logic signed [CALC_W-1:0] hyst_limit;
  logic [TEMP_W-1:0]        r_abs;
  logic [2*TEMP_W-1:0]      r_prod;
  logic [8:0]               q_abs;
  logic signed [CALC_W-1:0] q_s;
  logic signed [CALC_W-1:0] err_s;
  logic signed [CALC_W-1:0] prop_s;
  logic signed [CALC_W-1:0] power_s;

  always_comb begin
    r_s        = CALC_W'(return_temp_dc);
    f_s        = CALC_W'(flow_temp_dc);
    tgt_s      = signed'(CALC_W'(cfg.target_return_temp));
    pmax_s     = signed'(CALC_W'(cfg.auto_ceiling));
    tgt_x10    = CALC_W'(tgt_s * 16'sd10);
    flow_limit = CALC_W'((signed'(CALC_W'(cfg.max_flow_temp)) - 16'sd2) * 16'sd10);
    hyst_limit = CALC_W'((tgt_s - signed'(CALC_W'(cfg.hysteresis_deg))) * 16'sd10);

    // Division by ten truncated toward zero: divide the magnitude, restore the sign.
    r_abs  = return_temp_dc[TEMP_W-1] ? TEMP_W'(-return_temp_dc) : TEMP_W'(return_temp_dc);
    r_prod = r_abs * RECIP_TEN;
    q_abs  = r_prod[RECIP_SHIFT +: 9];
    q_s    = return_temp_dc[TEMP_W-1] ? -signed'(CALC_W'(q_abs)) : signed'(CALC_W'(q_abs));

    err_s  = tgt_s - q_s;
    prop_s = CALC_W'(16'sd20 + (err_s <<< 2));
    if (prop_s < 16'sd20) begin
      prop_s = 16'sd20;
    end
    if (cfg.mode == MODE_AUTO && prop_s > pmax_s) begin
      prop_s = pmax_s;
    end

    if (cfg.target_return_temp <= FROST_TARGET_MAX) begin
      // Frost protection: bang-bang around the target with half a degree of band.
      if (r_s <= 16'sd100 || r_s <= tgt_x10 - 16'sd5) begin
        power_s = pmax_s;
      end else if (r_s >= tgt_x10 + 16'sd5) begin
        power_s = '0;
      end else begin
        power_s = relay_state ? pmax_s : '0;
      end
    end else if (f_s >= flow_limit) begin
      power_s = '0;
    end else if (r_s <= hyst_limit) begin
      power_s = prop_s;
    end else if (r_s >= tgt_x10 + 16'sd10) begin
      power_s = '0;
    end else begin
      power_s = 16'sd20;
    end

    if (power_s > signed'(CALC_W'(POWER_MAX))) begin
      auto_power = POWER_MAX;
    end else if (power_s < 16'sd0) begin
      auto_power = '0;
    end else begin
      auto_power = power_s[6:0];
    end
  end

endmodule

### src/heater_power_pdm_controller.sv
// Heater relay controller using Bresenham pulse density modulation. Each input
// transfer carries one command: a one millisecond tick (advances the internal
// clock and, once per period_ms, steps the accumulator and drives the relay
// subject to the debounce window), a set-power request (clamped to the mode's
// ceiling and to 0..100), or an auto-power query (demand from return and flow
// temperatures in tenths of a degree). Every input transfer produces exactly one
// result transfer. The block takes one item per clock cycle while the result
// side is not stalled: an item is held in the input register, is worked out
// by a single pass of compares, adds and constant multiplies, and lands in the
// result register, from which the result is offered. A stalled result holds the
// result register and, through it, the input register; the input side stalls
// only when both registers are full. Configuration writes take effect in the
// cycle after their transfer and must only be issued while no item is in flight.
module heater_power_pdm_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic signed [15:0]              in_power_request,
  input  logic                            in_safety_block,
  input  logic signed [11:0]              in_return_temp_dc,
  input  logic signed [11:0]              in_flow_temp_dc,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_relay_on,
  output logic [6:0]                      out_power_level,
  output logic [6:0]                      out_auto_power,
  output logic                            out_pulse_fired,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hpc_pkg::*;

  hpc_cfg_t cfg;

  // Input register stage.
  logic               in_valid_r;
  logic               in_valid_nxt;
  logic [1:0]         cmd_r;
  logic signed [15:0] power_request_r;
  logic               safety_block_r;
  logic signed [11:0] return_temp_r;
  logic signed [11:0] flow_temp_r;

  // Controller state.
  logic [31:0] clock_ms_r,      clock_ms_nxt;
  logic [31:0] last_step_ms_r,  last_step_ms_nxt;
  logic [31:0] last_relay_ms_r, last_relay_ms_nxt;
  logic [7:0]  accumulator_r,   accumulator_nxt;
  logic        relay_state_r,   relay_state_nxt;
  logic [6:0]  power_target_r,  power_target_nxt;
  logic        fired_flag_r,    fired_flag_nxt;

  // Result register stage.
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [6:0] auto_power_r;
  logic [6:0] auto_power_nxt;

  logic in_take;
  logic advance;

  logic [31:0]        tick_clock;
  logic               step_due;
  logic               relay_open;
  logic               relay_wr;
  logic               relay_val;
  logic [7:0]         acc_sum;
  logic signed [15:0] ceiling_s;
  logic signed [15:0] req_s;
  logic [6:0]         query_power;

  hpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  hpc_auto_power u_auto (
    .cfg            (cfg),
    .relay_state    (relay_state_r),
    .return_temp_dc (return_temp_r),
    .flow_temp_dc   (flow_temp_r),
    .auto_power     (query_power)
  );

  // The held item moves on whenever the result register is empty or being drained.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // One pass of item processing; the state only moves when the item advances.
  always_comb begin
    clock_ms_nxt      = clock_ms_r;
    last_step_ms_nxt  = last_step_ms_r;
    last_relay_ms_nxt = last_relay_ms_r;
    accumulator_nxt   = accumulator_r;
    relay_state_nxt   = relay_state_r;
    power_target_nxt  = power_target_r;
    fired_flag_nxt    = fired_flag_r;
    auto_power_nxt    = '0;
    relay_wr          = 1'b0;
    relay_val         = 1'b0;

    tick_clock = clock_ms_r + 32'd1;
    step_due   = (tick_clock - last_step_ms_r) >= {16'd0, cfg.period_ms};
    relay_open = (tick_clock - last_relay_ms_r) >= {16'd0, cfg.debounce_ms};
    // The accumulator stays below full scale between steps, so eight bits hold the sum.
    acc_sum    = accumulator_r + {1'b0, power_target_r};

    ceiling_s = (cfg.mode == MODE_HAND) ? signed'({9'd0, cfg.manual_ceiling})
                                        : signed'({9'd0, cfg.auto_ceiling});
    req_s = power_request_r;
    if (req_s > ceiling_s) begin
      req_s = ceiling_s;
    end
    if (req_s < 16'sd0) begin
      req_s = 16'sd0;
    end
    if (req_s > 16'sd100) begin
      req_s = 16'sd100;
    end

    if (advance) begin
      case (cmd_r)
        CMD_TICK: begin
          clock_ms_nxt = tick_clock;
          if (step_due) begin
            last_step_ms_nxt = tick_clock;
            relay_wr         = 1'b1;
            if (safety_block_r || cfg.mode == MODE_DISABLED) begin
              accumulator_nxt = '0;
              fired_flag_nxt  = 1'b0;
            end else if (acc_sum >= PDM_FULL_SCALE) begin
              accumulator_nxt = acc_sum - PDM_FULL_SCALE;
              fired_flag_nxt  = 1'b1;
              relay_val       = 1'b1;
            end else begin
              accumulator_nxt = acc_sum;
              fired_flag_nxt  = 1'b0;
            end
          end
          // A relay write inside the debounce window is dropped.
          if (relay_wr && relay_open) begin
            relay_state_nxt   = relay_val;
            last_relay_ms_nxt = tick_clock;
          end
        end
        CMD_SET_POWER: begin
          power_target_nxt = req_s[6:0];
        end
        CMD_QUERY: begin
          auto_power_nxt = query_power;
        end
        default: begin
          auto_power_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      clock_ms_r      <= '0;
      last_step_ms_r  <= '0;
      last_relay_ms_r <= '0;
      accumulator_r   <= '0;
      relay_state_r   <= 1'b0;
      power_target_r  <= '0;
      fired_flag_r    <= 1'b0;
    end else begin
      in_valid_r      <= in_valid_nxt;
      out_valid_r     <= out_valid_nxt;
      clock_ms_r      <= clock_ms_nxt;
      last_step_ms_r  <= last_step_ms_nxt;
      last_relay_ms_r <= last_relay_ms_nxt;
      accumulator_r   <= accumulator_nxt;
      relay_state_r   <= relay_state_nxt;
      power_target_r  <= power_target_nxt;
      fired_flag_r    <= fired_flag_nxt;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r           <= in_cmd;
      power_request_r <= in_power_request;
      safety_block_r  <= in_safety_block;
      return_temp_r   <= in_return_temp_dc;
      flow_temp_r     <= in_flow_temp_dc;
    end
    if (advance) begin
      auto_power_r <= auto_power_nxt;
    end
  end

  // The relay, target and fired outputs show the state that the last
  // transferred item left; it moves only together with the result register.
  assign out_valid       = out_valid_r;
  assign out_relay_on    = relay_state_r;
  assign out_power_level = power_target_r;
  assign out_auto_power  = auto_power_r;
  assign out_pulse_fired = fired_flag_r;

endmodule

### src/hpc_checker.sv
module hpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_relay_on,
  input logic [6:0] out_power_level,
  input logic [6:0] out_auto_power,
  input logic       out_pulse_fired
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_relay_on) && $stable(out_power_level)
      && $stable(out_auto_power) && $stable(out_pulse_fired))
    else $error("result payload changed while stalled");

  // Power figures never leave the percent range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_power_level <= 7'd100 && out_auto_power <= 7'd100)
    else $error("power figure above one hundred percent");

  // The input side only stalls while work is backed up behind a stalled result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

bind heater_power_pdm_controller hpc_checker u_hpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_relay_on    (out_relay_on),
  .out_power_level (out_power_level),
  .out_auto_power  (out_auto_power),
  .out_pulse_fired (out_pulse_fired)
);

### tb/heater_power_pdm_controller_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the heater relay controller. The stimulus process
// fills a backlog of commands; a clocked driver presents them on the input
// channel, and every accepted transfer is run through a cycle-free model of
// the controller whose outcome is queued. A clocked monitor pops that queue
// for every result transfer and compares it field by field.
module heater_power_pdm_controller_test;
  import hpc_pkg::*;

  // Codes the package leaves unnamed but that the ports can still carry.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int SEGMENTS     = 9;
  localparam int SEGMENT_CMDS = 145;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] power_request;
    logic               safety_block;
    logic signed [11:0] return_temp_dc;
    logic signed [11:0] flow_temp_dc;
  } heater_cmd_t;

  typedef struct {
    logic       relay_on;
    logic [6:0] power_level;
    logic [6:0] auto_power;
    logic       pulse_fired;
  } heater_status_t;

  // Clock, reset and every block input start at a known value.
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_cmd = CMD_TICK;
  logic signed [15:0]       in_power_request = '0;
  logic                     in_safety_block = 1'b0;
  logic signed [11:0]       in_return_temp_dc = '0;
  logic signed [11:0]       in_flow_temp_dc = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_relay_on;
  logic [6:0]               out_power_level;
  logic [6:0]               out_auto_power;
  logic                     out_pulse_fired;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  heater_power_pdm_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_power_request  (in_power_request),
    .in_safety_block   (in_safety_block),
    .in_return_temp_dc (in_return_temp_dc),
    .in_flow_temp_dc   (in_flow_temp_dc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_relay_on      (out_relay_on),
    .out_power_level   (out_power_level),
    .out_auto_power    (out_auto_power),
    .out_pulse_fired   (out_pulse_fired),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The bench's own copy of the configuration registers and controller state.
  hpc_cfg_t    cfg_now;
  logic [31:0] ms_clock = '0;
  logic [31:0] step_stamp = '0;
  logic [31:0] relay_stamp = '0;
  logic [7:0]  pdm_acc = '0;
  logic        relay_is_on = 1'b0;
  logic [6:0]  target_pct = '0;
  logic        fired = 1'b0;

  heater_cmd_t    cmd_backlog[$];
  heater_status_t status_due[$];
  int             cmds_queued = 0;
  int             status_checked = 0;
  int             mismatches = 0;
  int             send_gap_pct = 27;
  int             stall_pct = 81;

  // A relay write is dropped when the last accepted one is too recent. The
  // subtraction wraps at 32 bits just like the millisecond clock does.
  function automatic void relay_request(input logic on);
    if (ms_clock - relay_stamp >= 32'(cfg_now.debounce_ms)) begin
      relay_is_on = on;
      relay_stamp = ms_clock;
    end
  endfunction

  // One millisecond tick; once a full period has passed the Bresenham
  // accumulator takes a step, unless the safety block or off mode clears it.
  function automatic void advance_ms(input logic block);
    ms_clock = ms_clock + 32'd1;
    if (ms_clock - step_stamp < 32'(cfg_now.period_ms)) return;
    step_stamp = ms_clock;
    if (block || cfg_now.mode == MODE_DISABLED) begin
      pdm_acc = '0;
      fired = 1'b0;
      relay_request(1'b0);
    end else begin
      pdm_acc = pdm_acc + 8'(target_pct);
      fired = (pdm_acc >= PDM_FULL_SCALE);
      if (fired) pdm_acc = pdm_acc - PDM_FULL_SCALE;
      relay_request(fired);
    end
  endfunction

  function automatic void set_target(input int req);
    int ceiling;
    ceiling = (cfg_now.mode == MODE_HAND) ? int'(cfg_now.manual_ceiling)
                                          : int'(cfg_now.auto_ceiling);
    if (req > ceiling) req = ceiling;
    if (req < 0) req = 0;
    if (req > int'(POWER_MAX)) req = int'(POWER_MAX);
    target_pct = 7'(req);
  endfunction

  // Heating demand from return and flow temperatures in tenths of a degree.
  // A low target selects frost protection, which holds the relay's last
  // decision inside a narrow band around the target.
  function automatic int heat_demand(input int r, input int f);
    int tgt;
    int pmax;
    int p;
    tgt  = int'(cfg_now.target_return_temp);
    pmax = int'(cfg_now.auto_ceiling);
    if (tgt <= int'(FROST_TARGET_MAX)) begin
      if (r <= 100 || r <= tgt * 10 - 5) return pmax;
      if (r >= tgt * 10 + 5) return 0;
      return relay_is_on ? pmax : 0;
    end
    if (f >= (int'(cfg_now.max_flow_temp) - 2) * 10) return 0;
    if (r <= (tgt - int'(cfg_now.hysteresis_deg)) * 10) begin
      // Integer division truncates toward zero, as the error term needs.
      p = 20 + 4 * (tgt - r / 10);
      if (p < 20) p = 20;
      if (cfg_now.mode == MODE_AUTO && p > pmax) p = pmax;
      return p;
    end
    if (r >= (tgt + 1) * 10) return 0;
    return 20;
  endfunction

  // Applies one accepted command to the bench state and returns the status
  // the block must report for it.
  function automatic heater_status_t next_status(input heater_cmd_t c);
    heater_status_t s;
    int demand;
    demand = 0;
    case (c.cmd)
      CMD_TICK:      advance_ms(c.safety_block);
      CMD_SET_POWER: set_target(c.power_request);
      CMD_QUERY: begin
        demand = heat_demand(c.return_temp_dc, c.flow_temp_dc);
        if (demand > int'(POWER_MAX)) demand = int'(POWER_MAX);
        if (demand < 0) demand = 0;
      end
      default: ;
    endcase
    s.relay_on    = relay_is_on;
    s.power_level = target_pct;
    s.auto_power  = 7'(demand);
    s.pulse_fired = fired;
    return s;
  endfunction

  function automatic logic [11:0] temp_near(input int centre, input int spread);
    return 12'(centre - spread + int'($urandom_range(2 * spread)));
  endfunction

  // Random command, biased toward the thresholds of the current setting.
  // Fields a command does not use still carry random bits.
  function automatic heater_cmd_t random_cmd();
    heater_cmd_t c;
    int pick;
    int tgt;
    int hyst;
    int flow_edge;
    int ceiling;
    tgt       = int'(cfg_now.target_return_temp);
    hyst      = int'(cfg_now.hysteresis_deg);
    flow_edge = (int'(cfg_now.max_flow_temp) - 2) * 10;
    ceiling   = (cfg_now.mode == MODE_HAND) ? int'(cfg_now.manual_ceiling)
                                            : int'(cfg_now.auto_ceiling);
    c.power_request  = 16'($urandom);
    c.safety_block   = ($urandom_range(9) == 0);
    c.return_temp_dc = 12'($urandom);
    c.flow_temp_dc   = 12'($urandom);
    pick = $urandom_range(99);
    if (pick < 52) c.cmd = CMD_TICK;
    else if (pick < 70) c.cmd = CMD_SET_POWER;
    else if (pick < 95) c.cmd = CMD_QUERY;
    else c.cmd = CMD_UNUSED;
    if (c.cmd == CMD_SET_POWER) begin
      case ($urandom_range(7))
        0:       c.power_request = 16'($urandom);
        1:       c.power_request = 16'(-int'($urandom_range(300)));
        2, 3:    c.power_request = 16'(ceiling - 3 + int'($urandom_range(6)));
        4:       c.power_request = 16'(int'($urandom_range(140, 95)));
        default: c.power_request = 16'(int'($urandom_range(100)));
      endcase
    end
    if (c.cmd == CMD_QUERY) begin
      case ($urandom_range(9))
        0:       c.return_temp_dc = 12'($urandom);
        1:       c.return_temp_dc = temp_near(100, 6);
        2:       c.return_temp_dc = temp_near(tgt * 10, 8);
        3:       c.return_temp_dc = temp_near((tgt - hyst) * 10, 4);
        4:       c.return_temp_dc = temp_near((tgt + 1) * 10, 4);
        5:       c.return_temp_dc = temp_near((tgt - hyst) * 10 - 300, 300);
        default: c.return_temp_dc = temp_near(475, 1025);
      endcase
      case ($urandom_range(5))
        0:       c.flow_temp_dc = 12'($urandom);
        1, 2:    c.flow_temp_dc = temp_near(flow_edge, 4);
        default: c.flow_temp_dc = temp_near(flow_edge - 300, 290);
      endcase
    end
    return c;
  endfunction

  function automatic heater_cmd_t cmd_of(input logic [1:0] cmd, input int req,
                                         input logic block, input int r,
                                         input int f);
    heater_cmd_t c;
    c.cmd            = cmd;
    c.power_request  = 16'(req);
    c.safety_block   = block;
    c.return_temp_dc = 12'(r);
    c.flow_temp_dc   = 12'(f);
    return c;
  endfunction

  task automatic enqueue(input heater_cmd_t c);
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  // Waits until every queued command has had its result checked, then lets
  // the pipeline drain before returning.
  task automatic settle();
    while (status_checked < cmds_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write transfer; the bench copy follows once it has landed.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:           cfg_now.mode = value[1:0];
      REG_TARGET_RETURN:  cfg_now.target_return_temp = value[6:0];
      REG_MAX_FLOW:       cfg_now.max_flow_temp = value[6:0];
      REG_HYSTERESIS:     cfg_now.hysteresis_deg = value[4:0];
      REG_AUTO_CEILING:   cfg_now.auto_ceiling = value[6:0];
      REG_MANUAL_CEILING: cfg_now.manual_ceiling = value[6:0];
      REG_PERIOD:         cfg_now.period_ms = value;
      REG_DEBOUNCE:       cfg_now.debounce_ms = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [1:0] mode, input int tgt,
                               input int flow, input int hyst, input int p_auto,
                               input int p_manual, input int period,
                               input int debounce);
    write_reg(REG_MODE, 16'(mode));
    write_reg(REG_TARGET_RETURN, 16'(tgt));
    write_reg(REG_MAX_FLOW, 16'(flow));
    write_reg(REG_HYSTERESIS, 16'(hyst));
    write_reg(REG_AUTO_CEILING, 16'(p_auto));
    write_reg(REG_MANUAL_CEILING, 16'(p_manual));
    write_reg(REG_PERIOD, 16'(period));
    write_reg(REG_DEBOUNCE, 16'(debounce));
  endtask

  // Short periods keep the accumulator busy; the rest walks through frost
  // protection, off and spare modes, a zero period, and both field extremes.
  task automatic program_setting(input int k);
    case (k)
      0: apply_setting(MODE_AUTO,      40,  75,  3, 100, 100,     1,     0);
      1: apply_setting(MODE_HAND,      10,  60,  5,  80,  55,     3,     2);
      2: apply_setting(MODE_DISABLED,  15, 120, 20, 100, 100,     2,     1);
      3: apply_setting(MODE_SPARE,     16,   0,  0,   0, 127,     1,     3);
      4: apply_setting(MODE_AUTO,     100,  30, 31,  50, 100,     0,     0);
      5: apply_setting(MODE_HAND,       0, 127,  1, 127, 100,     4, 65535);
      6: apply_setting(MODE_AUTO,     127,  90, 10, 120,   0, 65535,     0);
      7: apply_setting(MODE_AUTO,      55,  70,  4,  90,  70,     2,     5);
      default: apply_setting(MODE_HAND, 25, 45, 2, 100, 100, 1, 1);
    endcase
  endtask

  // Driver. A payload stays put while it is stalled; a new one is taken from
  // the backlog only when the slot is free, and the random gap decides
  // whether it is offered in this cycle or the channel idles. Each accepted
  // transfer goes through the bench model right at the accepting edge.
  heater_cmd_t cmd_on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) status_due.push_back(next_status(cmd_on_bus));
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          cmd_on_bus = cmd_backlog.pop_front();
          in_valid          <= 1'b1;
          in_cmd            <= cmd_on_bus.cmd;
          in_power_request  <= cmd_on_bus.power_request;
          in_safety_block   <= cmd_on_bus.safety_block;
          in_return_temp_dc <= cmd_on_bus.return_temp_dc;
          in_flow_temp_dc   <= cmd_on_bus.flow_temp_dc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(input string field, input logic [6:0] got,
                                        input logic [6:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Monitor. Every result transfer must match the oldest pending prediction.
  // The stall for the next cycle is drawn afresh each edge.
  always @(posedge clk) begin : result_monitor
    heater_status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %0b %0d %0d %0b",
                   $time, out_relay_on, out_power_level, out_auto_power,
                   out_pulse_fired);
        end else begin
          want = status_due.pop_front();
          status_checked++;
          compare_field("relay_on", 7'(out_relay_on), 7'(want.relay_on));
          compare_field("power_level", out_power_level, want.power_level);
          compare_field("auto_power", out_auto_power, want.auto_power);
          compare_field("pulse_fired", 7'(out_pulse_fired), 7'(want.pulse_fired));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: the run is far shorter than this even with the heaviest idling.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    // Register values after reset.
    cfg_now.mode               = MODE_AUTO;
    cfg_now.target_return_temp = 7'd40;
    cfg_now.max_flow_temp      = 7'd75;
    cfg_now.hysteresis_deg     = 5'd3;
    cfg_now.auto_ceiling       = 7'd100;
    cfg_now.manual_ceiling     = 7'd100;
    cfg_now.period_ms          = 16'd1000;
    cfg_now.debounce_ms        = 16'd100;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands at the reset setting: the request extremes and the
    // clamps, ticks with and without the safety block, the unused command
    // code, and queries at each threshold of normal heating.
    enqueue(cmd_of(CMD_SET_POWER, 32767, 1'b0, 0, 0));
    enqueue(cmd_of(CMD_SET_POWER, -32768, 1'b1, -2048, -2048));
    enqueue(cmd_of(CMD_SET_POWER, 101, 1'b0, 0, 0));
    enqueue(cmd_of(CMD_SET_POWER, -1, 1'b0, 0, 0));
    enqueue(cmd_of(CMD_SET_POWER, 60, 1'b0, 0, 0));
    enqueue(cmd_of(CMD_TICK, 0, 1'b1, 0, 0));
    enqueue(cmd_of(CMD_TICK, -1, 1'b0, 2047, 2047));
    enqueue(cmd_of(CMD_UNUSED, 32767, 1'b1, 2047, -2048));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, -2048, -2048));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 2047, 2047));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 370, 729));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 371, 0));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 409, 730));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 410, 0));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 100, 0));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, -15, -550));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, -550, 1500));
    enqueue(cmd_of(CMD_QUERY, 0, 1'b0, 1500, 100));
    enqueue(cmd_of(CMD_SET_POWER, 100, 1'b0, 0, 0));

    // Random segments. Each one starts from an idle block with a fresh
    // setting; the first three stall the results heavily, the next three
    // starve the input, and the last three run without any idling.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      send_gap_pct = (seg < 3) ? 27 : (seg < 6) ? 81 : 0;
      stall_pct    = (seg < 3) ? 81 : (seg < 6) ? 27 : 0;
      program_setting(seg);
      repeat (SEGMENT_CMDS) enqueue(random_cmd());
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
